### rtl/pwo_pkg.sv
// Shared types, codes and constants of the wavetable oscillator.
package pwo_pkg;

    // item actions
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_NOTE_ON  = 3'd1;
    localparam logic [2:0] ACT_NOTE_OFF = 3'd2;
    localparam logic [2:0] ACT_ALL_OFF  = 3'd3;
    localparam logic [2:0] ACT_LOAD     = 3'd4;

    // configuration register indexes
    localparam logic CFG_DEPTH = 1'b0;
    localparam logic CFG_RATE  = 1'b1;

    localparam int unsigned SLOTS   = 8;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned VOICES  = 8;
    localparam int unsigned PHASE_W = 15;
    localparam int unsigned TBL_W   = 8;
    localparam int unsigned SMP_W   = 8;
    localparam int unsigned SUM_W   = 11;
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned RATE_W  = 10;
    localparam int unsigned OFS_W   = 10;
    localparam int unsigned AMP_W   = 9;
    localparam int unsigned DIV_W   = 14;

    localparam int unsigned PHASE_WRAP = 25600;
    localparam int unsigned RATE_SCALE = 10;

    // phase / 100 == (phase * 5243) >> 19 for every phase below the wrap
    localparam int unsigned RECIP100    = 5243;
    localparam int unsigned RECIP100_SH = 19;
    // depth / 7 == (depth * 9363) >> 16 for every 11-bit depth
    localparam int unsigned RECIP7      = 9363;
    localparam int unsigned RECIP7_SH   = 16;

    typedef struct packed {
        logic [PHASE_W-1:0] step;
        logic [PHASE_W-1:0] phase;
    } t_voice;

    typedef struct packed {
        logic             en;
        logic             index;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                      start;
        logic [ACT_W-1:0]          action;
        logic [PHASE_W-1:0]        note_step;
        logic [TBL_W-1:0]          wave_address;
        logic [SMP_W-1:0]          wave_value;
        logic signed [OFS_W-1:0]   offset;
    } t_eng_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_eng_rsp;

endpackage

### rtl/pwo_if.sv
// Channel interfaces: input item, result word and configuration write.
interface pwo_item_if;
    logic                           valid;
    logic                           ready;
    logic [pwo_pkg::ACT_W-1:0]      action;
    logic [pwo_pkg::PHASE_W-1:0]    note_step;
    logic [pwo_pkg::TBL_W-1:0]      wave_address;
    logic [pwo_pkg::SMP_W-1:0]      wave_value;

    modport source (output valid, action, note_step, wave_address, wave_value, input ready);
    modport sink   (input valid, action, note_step, wave_address, wave_value, output ready);
endinterface

interface pwo_result_if;
    logic                           valid;
    logic                           ready;
    logic [pwo_pkg::SMP_W-1:0]      sample;
    logic                           sample_valid;
    logic [pwo_pkg::CNT_W-1:0]      active_voices;

    modport source (output valid, sample, sample_valid, active_voices, input ready);
    modport sink   (input valid, sample, sample_valid, active_voices, output ready);
endinterface

interface pwo_cfg_if;
    logic                           valid;
    logic                           ready;
    logic                           index;
    logic [pwo_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pwo_vibrato.sv
// Vibrato: tick divider, triangle offset and its configuration registers.
module pwo_vibrato (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pwo_pkg::t_cfg_wr                    i_cfg,
    input  logic                                i_advance,
    output logic signed [pwo_pkg::OFS_W-1:0]    o_offset
);

    logic [pwo_pkg::AMP_W-1:0]          r_amp;
    logic [pwo_pkg::DIV_W-1:0]          r_rate10;
    logic [pwo_pkg::DIV_W-1:0]          r_div;
    logic [1:0]                         r_mode;
    logic signed [pwo_pkg::OFS_W-1:0]   r_offset;

    logic [pwo_pkg::DIV_W-1:0]          n_div;
    logic [1:0]                         n_mode;
    logic signed [pwo_pkg::OFS_W-1:0]   n_offset;
    logic [24:0]                        amp_prod;
    logic [pwo_pkg::DIV_W-1:0]          rate10;
    logic [pwo_pkg::RATE_W-1:0]         rate_in;
    logic signed [pwo_pkg::OFS_W-1:0]   amp_s;
    logic [pwo_pkg::DIV_W-1:0]          div_inc;

    assign amp_prod = 25'(i_cfg.data) * 25'(pwo_pkg::RECIP7);
    assign rate_in  = i_cfg.data[pwo_pkg::RATE_W-1:0];
    assign rate10   = {rate_in, 3'b000} + {3'b000, rate_in, 1'b0};
    assign amp_s    = $signed({1'b0, r_amp});
    assign div_inc  = r_div + 1'b1;

    // the three mode tests run in sequence within one step
    always_comb begin
        n_div    = r_div;
        n_mode   = r_mode;
        n_offset = r_offset;
        if (i_advance) begin
            n_div = div_inc;
            if (div_inc > r_rate10) begin
                n_div = '0;
                if (n_mode == 2'd0) begin
                    n_offset = n_offset + 10'sd1;
                    if (n_offset > amp_s) n_mode = 2'd1;
                end
                if (n_mode == 2'd1) begin
                    n_offset = n_offset - 10'sd1;
                    if (n_offset < -amp_s) n_mode = 2'd2;
                end
                if (n_mode == 2'd2) begin
                    n_offset = n_offset + 10'sd1;
                    if (n_offset == 10'sd0) n_mode = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp    <= '0;
            r_rate10 <= '0;
            r_div    <= '0;
            r_mode   <= 2'd0;
            r_offset <= '0;
        end else begin
            r_div    <= n_div;
            r_mode   <= n_mode;
            r_offset <= n_offset;
            if (i_cfg.en) begin
                case (i_cfg.index)
                    pwo_pkg::CFG_DEPTH: begin
                        r_amp <= amp_prod[pwo_pkg::RECIP7_SH +: pwo_pkg::AMP_W];
                    end
                    pwo_pkg::CFG_RATE: begin
                        r_rate10 <= rate10;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_offset = r_offset;

endmodule

### rtl/pwo_voice_engine.sv
// Voice engine: voice memory and wave memory with the read-modify-write walk.
module pwo_voice_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pwo_pkg::t_eng_req   i_req,
    output pwo_pkg::t_eng_rsp   o_rsp
);

    pwo_pkg::t_voice                    r_vmem [pwo_pkg::SLOTS];
    pwo_pkg::t_voice                    r_vrd;
    logic [pwo_pkg::SMP_W-1:0]          r_wmem [2**pwo_pkg::TBL_W];
    logic [pwo_pkg::SMP_W-1:0]          r_wrd;

    logic                               r_busy;
    logic [pwo_pkg::ACT_W-1:0]          r_op;
    logic [pwo_pkg::PHASE_W-1:0]        r_step;
    logic signed [pwo_pkg::OFS_W-1:0]   r_offset;
    logic [pwo_pkg::CNT_W-1:0]          r_count;
    logic [pwo_pkg::CNT_W-1:0]          r_rd_idx;
    logic [pwo_pkg::CNT_W-1:0]          r_kept;
    logic                               r_s1_v;
    logic [pwo_pkg::SLOT_W-1:0]         r_s1_idx;
    logic                               r_s2_v;
    logic [pwo_pkg::PHASE_W-1:0]        r_s2_ph;
    logic                               r_s3_v;
    logic [pwo_pkg::SUM_W-1:0]          r_sum;

    logic                               walk;
    logic                               issue;
    logic                               finish;
    logic                               is_tick;
    logic                               is_off;
    logic                               keep;
    logic signed [16:0]                 inc_raw;
    logic [pwo_pkg::PHASE_W-1:0]        inc;
    logic [pwo_pkg::PHASE_W:0]          ph_sum;
    logic [pwo_pkg::PHASE_W-1:0]        new_ph;
    logic [27:0]                        idx_prod;
    logic [pwo_pkg::TBL_W-1:0]          wave_idx;
    logic                               vw_en;
    logic [pwo_pkg::SLOT_W-1:0]         vw_addr;
    pwo_pkg::t_voice                    vw_data;
    logic                               start_on;

    assign is_tick = (r_op == pwo_pkg::ACT_TICK);
    assign is_off  = (r_op == pwo_pkg::ACT_NOTE_OFF);
    assign walk    = is_tick || is_off;
    assign issue   = r_busy && walk && (r_rd_idx < r_count);
    assign finish  = r_busy && !issue && !r_s1_v && !r_s2_v && !r_s3_v;
    assign keep    = r_vrd.step != r_step;

    // effective increment, clamped, then one wrap
    always_comb begin
        inc_raw = $signed({2'b00, r_vrd.step}) + 17'(r_offset);
        if (inc_raw < 17'sd0) begin
            inc = '0;
        end else if (inc_raw > 17'(pwo_pkg::PHASE_WRAP - 1)) begin
            inc = 15'(pwo_pkg::PHASE_WRAP - 1);
        end else begin
            inc = inc_raw[pwo_pkg::PHASE_W-1:0];
        end
        ph_sum = {1'b0, r_vrd.phase} + {1'b0, inc};
        if (ph_sum >= 16'(pwo_pkg::PHASE_WRAP)) begin
            new_ph = 15'(ph_sum - 16'(pwo_pkg::PHASE_WRAP));
        end else begin
            new_ph = ph_sum[pwo_pkg::PHASE_W-1:0];
        end
    end

    assign idx_prod = 28'(r_s2_ph) * 28'(pwo_pkg::RECIP100);
    assign wave_idx = idx_prod[pwo_pkg::RECIP100_SH +: pwo_pkg::TBL_W];

    assign start_on = i_req.start && (i_req.action == pwo_pkg::ACT_NOTE_ON)
                      && (r_count < 4'(pwo_pkg::SLOTS));

    // note-off writes land at or below the slot just read, never the one being read
    always_comb begin
        vw_en   = 1'b0;
        vw_addr = r_s1_idx;
        vw_data = r_vrd;
        if (start_on) begin
            vw_en   = 1'b1;
            vw_addr = r_count[pwo_pkg::SLOT_W-1:0];
            vw_data = '{step: i_req.note_step, phase: '0};
        end else if (r_s1_v && is_tick) begin
            vw_en   = 1'b1;
            vw_data = '{step: r_vrd.step, phase: new_ph};
        end else if (r_s1_v && is_off && keep) begin
            vw_en   = 1'b1;
            vw_addr = r_kept[pwo_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_vrd <= r_vmem[r_rd_idx[pwo_pkg::SLOT_W-1:0]];
        if (vw_en) begin
            r_vmem[vw_addr] <= vw_data;
        end
        r_wrd <= r_wmem[wave_idx];
        if (i_req.start && (i_req.action == pwo_pkg::ACT_LOAD)) begin
            r_wmem[i_req.wave_address] <= i_req.wave_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_rd_idx[pwo_pkg::SLOT_W-1:0];
        r_s2_ph  <= new_ph;
        if (i_req.start) begin
            r_step   <= i_req.note_step;
            r_offset <= i_req.offset;
            r_sum    <= '0;
        end else if (r_s3_v) begin
            r_sum <= r_sum + {3'b000, r_wrd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_op     <= pwo_pkg::ACT_TICK;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_kept   <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v && is_tick;
            r_s3_v <= r_s2_v;
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_s1_v && is_off && keep) begin
                r_kept <= r_kept + 1'b1;
            end
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_op     <= i_req.action;
                r_rd_idx <= '0;
                r_kept   <= '0;
                if (start_on) begin
                    r_count <= r_count + 1'b1;
                end else if (i_req.action == pwo_pkg::ACT_ALL_OFF) begin
                    r_count <= '0;
                end
            end else if (finish) begin
                r_busy <= 1'b0;
                if (is_off) begin
                    r_count <= r_kept;
                end
            end
        end
    end

    assign o_rsp.done  = finish;
    assign o_rsp.sum   = r_sum;
    assign o_rsp.count = is_off ? r_kept : r_count;

endmodule

### rtl/polyphonic_wavetable_oscillator.sv
// Top level: item sequencing, configuration port and result register.
//
// Eight-voice wavetable oscillator with a shared triangle vibrato. Every input
// word gives exactly one result word. A sample tick walks the sounding voices
// through the voice memory, one entry read per cycle, and mixes their wave
// memory bytes through a three-stage phase/lookup/sum tail. Note off walks
// the voices the same way, keeping those it does not release, but without the
// lookup and sum; note on, all notes off and wave loads need no walk. Items
// are taken one at a time; the result register lets the next word in while a
// result waits. The wave memory has no reset: load every entry the ticks will
// read before sounding notes. Configuration writes are taken at any time but
// belong only where no item is in flight.
module polyphonic_wavetable_oscillator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pwo_item_if.sink        i_item,
    pwo_result_if.source    o_result,
    pwo_cfg_if.sink         i_cfg
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    logic [1:0]                         r_state;
    logic [pwo_pkg::ACT_W-1:0]          r_act;
    logic [pwo_pkg::PHASE_W-1:0]        r_step;
    logic [pwo_pkg::TBL_W-1:0]          r_addr;
    logic [pwo_pkg::SMP_W-1:0]          r_val;
    logic [pwo_pkg::SMP_W-1:0]          r_res_sample;
    logic                               r_res_svalid;
    logic [pwo_pkg::CNT_W-1:0]          r_res_count;
    logic                               r_o_valid;
    logic [pwo_pkg::SMP_W-1:0]          r_o_sample;
    logic                               r_o_svalid;
    logic [pwo_pkg::CNT_W-1:0]          r_o_count;

    logic                               accept;
    logic                               out_free;
    logic                               advance;
    logic signed [pwo_pkg::OFS_W-1:0]   offset;
    logic [pwo_pkg::SUM_W-1:0]          quot;
    logic [pwo_pkg::SMP_W-1:0]          mixed;
    pwo_pkg::t_cfg_wr                   cfg_wr;
    pwo_pkg::t_eng_req                  eng_req;
    pwo_pkg::t_eng_rsp                  eng_rsp;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_o_valid || o_result.ready;
    assign advance      = accept && (i_item.action == pwo_pkg::ACT_TICK);

    assign cfg_wr = '{en: i_cfg.valid, index: i_cfg.index, data: i_cfg.data};

    pwo_vibrato u_vibrato (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_wr),
        .i_advance (advance),
        .o_offset  (offset)
    );

    assign eng_req = '{
        start:        (r_state == S_START),
        action:       r_act,
        note_step:    r_step,
        wave_address: r_addr,
        wave_value:   r_val,
        offset:       offset
    };

    pwo_voice_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .o_rsp   (eng_rsp)
    );

    assign quot  = eng_rsp.sum / 11'(pwo_pkg::VOICES);
    assign mixed = (quot > 11'd255) ? 8'hFF : quot[pwo_pkg::SMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_item.action;
            r_step <= i_item.note_step;
            r_addr <= i_item.wave_address;
            r_val  <= i_item.wave_value;
        end
        if ((r_state == S_RUN) && eng_rsp.done) begin
            r_res_svalid <= (r_act == pwo_pkg::ACT_TICK);
            r_res_sample <= (r_act == pwo_pkg::ACT_TICK) ? mixed : '0;
            r_res_count  <= eng_rsp.count;
        end
        if ((r_state == S_PUSH) && out_free) begin
            r_o_sample <= r_res_sample;
            r_o_svalid <= r_res_svalid;
            r_o_count  <= r_res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if ((r_state == S_PUSH) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (eng_rsp.done) r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.sample        = r_o_sample;
    assign o_result.sample_valid  = r_o_svalid;
    assign o_result.active_voices = r_o_count;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the eight-voice wavetable oscillator.
`timescale 1ns / 100ps

module testbench;
    import pwo_pkg::*;

    localparam int PHASE_LIMIT  = PHASE_WRAP;
    localparam int PHASE_STEP   = 100;
    localparam int DEPTH_SCALE  = 7;
    localparam int RATE_MULT    = RATE_SCALE;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 50;

    typedef enum logic [1:0] {
        VIB_RISE   = 2'd0,
        VIB_FALL   = 2'd1,
        VIB_RETURN = 2'd2
    } t_vib_mode;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [PHASE_W-1:0] note_step;
        logic [TBL_W-1:0]   wave_address;
        logic [SMP_W-1:0]   wave_value;
    } t_osc_item;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             sample_valid;
        logic [CNT_W-1:0] active_voices;
    } t_mix_result;

    logic i_clk;
    logic i_rst_n;

    pwo_item_if   item_if ();
    pwo_result_if result_if ();
    pwo_cfg_if    cfg_if ();

    polyphonic_wavetable_oscillator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // predictor state
    int                 voice_phase [SLOTS];
    int                 voice_step  [SLOTS];
    int                 voice_cnt;
    logic [TBL_W-1:0]   wave_mem [256];
    int                 vib_offset;
    t_vib_mode          vib_mode;
    logic [DIV_W-1:0]   tick_div;
    int                 vib_depth;
    int                 vib_rate;

    t_osc_item          item_backlog [$];
    t_mix_result        pending_results [$];
    int unsigned        recent_steps [$];
    t_osc_item          cur_item;

    int send_idle_pct;
    int stall_pct;
    int hold_trigger;
    int hold_taken;
    int hold_left;

    int error_count;
    int items_accepted;
    int results_checked;
    int tick_count;
    int note_on_count;
    int note_off_count;
    int clamp_count;
    int reversal_count;
    int config_writes;
    int cycle_count;

    function automatic void advance_vibrato();
        int amp;
        amp = vib_depth / DEPTH_SCALE;
        // the three mode tests fall through within one step
        if (vib_mode == VIB_RISE) begin
            vib_offset = vib_offset + 1;
            if (vib_offset > amp) begin
                vib_mode = VIB_FALL;
                reversal_count++;
            end
        end
        if (vib_mode == VIB_FALL) begin
            vib_offset = vib_offset - 1;
            if (vib_offset < -amp) begin
                vib_mode = VIB_RETURN;
                reversal_count++;
            end
        end
        if (vib_mode == VIB_RETURN) begin
            vib_offset = vib_offset + 1;
            if (vib_offset == 0) vib_mode = VIB_RISE;
        end
    endfunction

    function automatic t_mix_result oscillator_step(t_osc_item it);
        t_mix_result r;
        int sum;
        int inc;
        int ph;
        int kept;
        r = '0;
        case (it.action)
            ACT_TICK: begin
                tick_count++;
                tick_div = tick_div + 1'b1;
                if (int'(tick_div) > vib_rate * RATE_MULT) begin
                    advance_vibrato();
                    tick_div = '0;
                end
                sum = 0;
                for (int i = 0; i < voice_cnt; i++) begin
                    inc = voice_step[i] + vib_offset;
                    if (inc < 0 || inc > PHASE_LIMIT - 1) clamp_count++;
                    if (inc < 0) inc = 0;
                    if (inc > PHASE_LIMIT - 1) inc = PHASE_LIMIT - 1;
                    ph = voice_phase[i] + inc;
                    if (ph >= PHASE_LIMIT) ph = ph - PHASE_LIMIT;
                    voice_phase[i] = ph;
                    sum = sum + int'(wave_mem[ph / PHASE_STEP]);
                end
                sum = sum / VOICES;
                if (sum > 255) sum = 255;
                r.sample = sum[SMP_W-1:0];
                r.sample_valid = 1'b1;
            end
            ACT_NOTE_ON: begin
                note_on_count++;
                if (voice_cnt < SLOTS) begin
                    voice_step[voice_cnt] = int'(it.note_step);
                    voice_phase[voice_cnt] = 0;
                    voice_cnt++;
                end
            end
            ACT_NOTE_OFF: begin
                note_off_count++;
                if (voice_cnt != 0) begin
                    kept = 0;
                    for (int i = 0; i < voice_cnt; i++) begin
                        if (voice_step[i] != int'(it.note_step)) begin
                            voice_step[kept] = voice_step[i];
                            voice_phase[kept] = voice_phase[i];
                            kept++;
                        end
                    end
                    for (int i = kept; i < SLOTS; i++) begin
                        voice_step[i] = 0;
                        voice_phase[i] = 0;
                    end
                    voice_cnt = kept;
                end
            end
            ACT_ALL_OFF: begin
                for (int i = 0; i < SLOTS; i++) begin
                    voice_step[i] = 0;
                    voice_phase[i] = 0;
                end
                voice_cnt = 0;
            end
            ACT_LOAD: begin
                wave_mem[it.wave_address] = it.wave_value;
            end
            default: ;
        endcase
        r.active_voices = voice_cnt[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at word %0d: %s got %0d expected %0d", results_checked, what, got,
                 want);
        error_count++;
    endtask

    // driver: one word in flight on the item channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                pending_results.push_back(oscillator_step(cur_item));
                items_accepted++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = item_backlog.pop_front();
                    item_if.valid        <= 1'b1;
                    item_if.action       <= cur_item.action;
                    item_if.note_step    <= cur_item.note_step;
                    item_if.wave_address <= cur_item.wave_address;
                    item_if.wave_value   <= cur_item.wave_value;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: result ready pattern, long hold-off and field compare
    always @(posedge i_clk) begin
        t_mix_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            hold_left       <= 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word, sample", int'(result_if.sample),
                                    -1);
                end else begin
                    want = pending_results.pop_front();
                    if (result_if.sample !== want.sample)
                        report_mismatch("sample", int'(result_if.sample), int'(want.sample));
                    if (result_if.sample_valid !== want.sample_valid)
                        report_mismatch("sample_valid", int'(result_if.sample_valid),
                                        int'(want.sample_valid));
                    if (result_if.active_voices !== want.active_voices)
                        report_mismatch("active_voices", int'(result_if.active_voices),
                                        int'(want.active_voices));
                end
                results_checked++;
            end
            if (hold_trigger != hold_taken) begin
                hold_taken      <= hold_trigger;
                hold_left       <= HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left       <= hold_left - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d words still expected", cycle_count,
                     pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_item(logic [ACT_W-1:0] act, int unsigned step, int unsigned addr,
                             int unsigned val);
        t_osc_item it;
        it.action       = act;
        it.note_step    = step[PHASE_W-1:0];
        it.wave_address = addr[TBL_W-1:0];
        it.wave_value   = val[SMP_W-1:0];
        item_backlog.push_back(it);
    endtask

    function automatic int unsigned pick_step();
        int unsigned sel;
        sel = $urandom_range(9);
        // lean on the ends of the range so the increment clamps get hit
        if (sel < 2) return $urandom_range(7);
        if (sel < 4) return PHASE_LIMIT - 1 - $urandom_range(7);
        return $urandom_range(PHASE_LIMIT - 1);
    endfunction

    task automatic queue_random_items(int count);
        int unsigned pick;
        int unsigned step;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            step = pick_step();
            if (pick < 52) begin
                push_item(ACT_TICK, step, $urandom_range(255), $urandom_range(255));
            end else if (pick < 72) begin
                recent_steps.push_back(step);
                if (recent_steps.size() > SLOTS) recent_steps.delete(0);
                push_item(ACT_NOTE_ON, step, $urandom_range(255), $urandom_range(255));
            end else if (pick < 85) begin
                // mostly release a note that is likely sounding
                if (recent_steps.size() != 0 && $urandom_range(9) < 8)
                    step = recent_steps[$urandom_range(recent_steps.size() - 1)];
                push_item(ACT_NOTE_OFF, step, $urandom_range(255), $urandom_range(255));
            end else if (pick < 88) begin
                push_item(ACT_ALL_OFF, step, $urandom_range(255), $urandom_range(255));
            end else begin
                push_item(ACT_LOAD, step, $urandom_range(255), $urandom_range(255));
            end
        end
    endtask

    task automatic write_register(logic idx, int unsigned value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value[CFG_W-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_DEPTH) vib_depth = value;
        else vib_rate = value;
        config_writes++;
    endtask

    task automatic wait_idle();
        while (item_backlog.size() != 0 || item_if.valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(int unsigned depth, int unsigned rate, int send_pct, int rx_pct,
                             int count, bit long_hold);
        write_register(CFG_DEPTH, depth);
        write_register(CFG_RATE, rate);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        queue_random_items(count);
        if (long_hold) begin
            repeat (20) @(posedge i_clk);
            hold_trigger <= hold_trigger + 1;
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.action       = ACT_TICK;
        item_if.note_step    = '0;
        item_if.wave_address = '0;
        item_if.wave_value   = '0;
        result_if.ready      = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_DEPTH;
        cfg_if.data          = '0;
        for (int i = 0; i < SLOTS; i++) begin
            voice_phase[i] = 0;
            voice_step[i]  = 0;
        end
        for (int i = 0; i < 256; i++) wave_mem[i] = '0;
        voice_cnt       = 0;
        vib_offset      = 0;
        vib_mode        = VIB_RISE;
        tick_div        = '0;
        vib_depth       = 0;
        vib_rate        = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_trigger    = 0;
        hold_taken      = 0;
        error_count     = 0;
        items_accepted  = 0;
        results_checked = 0;
        tick_count      = 0;
        note_on_count   = 0;
        note_off_count  = 0;
        clamp_count     = 0;
        reversal_count  = 0;
        config_writes   = 0;
        cycle_count     = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // wave memory has no reset: fill every entry before any voice sounds
        for (int a = 0; a < 256; a++) push_item(ACT_LOAD, 0, a, $urandom_range(255));

        push_item(ACT_TICK, 0, 0, 0);
        push_item(ACT_NOTE_OFF, 100, 0, 0);
        push_item(ACT_NOTE_ON, 0, 0, 0);
        push_item(ACT_NOTE_ON, PHASE_LIMIT - 1, 0, 0);
        push_item(ACT_TICK, 0, 255, 255);
        push_item(ACT_NOTE_ON, 12800, 0, 0);
        push_item(ACT_NOTE_ON, PHASE_LIMIT - 1, 0, 0);
        push_item(ACT_NOTE_ON, 1, 0, 0);
        push_item(ACT_NOTE_ON, 16384, 0, 0);
        push_item(ACT_NOTE_ON, 255, 0, 0);
        push_item(ACT_NOTE_ON, PHASE_LIMIT - 1, 0, 0);
        push_item(ACT_NOTE_ON, 777, 0, 0);              // full, dropped
        push_item(ACT_TICK, 0, 0, 0);
        push_item(ACT_TICK, 0, 0, 0);
        push_item(ACT_NOTE_OFF, PHASE_LIMIT - 1, 0, 0); // three copies go
        push_item(ACT_TICK, 0, 0, 0);
        push_item(ACT_NOTE_OFF, 5, 0, 0);               // not sounding
        push_item(ACT_LOAD, 32767, 0, 0);
        push_item(ACT_LOAD, 0, 255, 255);
        push_item(ACT_LOAD, 0, 128, 170);
        push_item(ACT_TICK, 32767, 0, 0);
        push_item(ACT_ALL_OFF, 0, 0, 0);
        push_item(ACT_TICK, 0, 0, 0);
        push_item(ACT_NOTE_ON, 32, 0, 0);
        push_item(ACT_TICK, 0, 0, 0);
        queue_random_items(300);
        wait_idle();

        run_phase(2047, 0, 61, 0, 300, 1'b0);
        run_phase(70, 1023, 0, 61, 300, 1'b0);
        run_phase($urandom_range(2047), $urandom_range(3), 22, 22, 300, 1'b0);
        run_phase(13, 1, 0, 0, 300, 1'b1);
        run_phase(0, $urandom_range(1023), 0, 0, 300, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d words (%0d ticks, %0d note on, %0d note off), %0d register writes",
                 items_accepted, tick_count, note_on_count, note_off_count, config_writes);
        $display("Vibrato turned %0d times, %0d clamped increments, %0d results compared",
                 reversal_count, clamp_count, results_checked);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
rtl/pwo_pkg.sv
rtl/pwo_if.sv
rtl/pwo_vibrato.sv
rtl/pwo_voice_engine.sv
rtl/polyphonic_wavetable_oscillator.sv
tb/sv/testbench.sv
